// ===== sv/dfs_pkg.sv =====
// Shared types and constants for the directional focus search block.
// Used by dfs_feat, dfs_sel and the directional_focus_search top level.
package dfs_pkg;

  // Search direction codes, as written to the direction register.
  localparam int unsigned DIR_W = 2;

  typedef enum logic [DIR_W-1:0] {
    DIR_LEFT  = 2'd0,
    DIR_UP    = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DIR        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_RIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_BOTTOM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_ID    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_ID    = 3'd6;

  // Per-rectangle geometric flags relative to the source.
  typedef struct packed {
    logic in_dir;   // lies at least partly in the search direction
    logic beam;     // overlaps the source beam
    logic toward;   // lies completely beyond the source edge
  } feat_flags_t;

endpackage

// ===== sv/dfs_feat.sv =====
// Two-stage feature unit: direction, beam and distance terms of one rectangle.
// Depends on dfs_pkg for the direction codes and the flag struct.
module dfs_feat #(
  parameter int unsigned W = 18
) (
  input  logic                        clk_i,
  input  logic                        en1_i,
  input  logic                        en2_i,
  input  dfs_pkg::dir_e               dir_i,
  input  logic signed [W-1:0]         src_left_i,
  input  logic signed [W-1:0]         src_top_i,
  input  logic signed [W-1:0]         src_right_i,
  input  logic signed [W-1:0]         src_bottom_i,
  input  logic signed [W-1:0]         box_left_i,
  input  logic signed [W-1:0]         box_top_i,
  input  logic signed [W-1:0]         box_right_i,
  input  logic signed [W-1:0]         box_bottom_i,
  output dfs_pkg::feat_flags_t        flags_o,
  output logic        [W-1:0]         near_o,
  output logic        [W-1:0]         far_o,
  output logic        [2*W+3:0]       wt_o
);
  import dfs_pkg::*;

  localparam int unsigned SQ_W = 2 * W;
  localparam int unsigned WT_W = 2 * W + 4;

  // Exact difference of two W-bit signed values.
  function automatic logic signed [W:0] sub(input logic signed [W-1:0] a,
                                            input logic signed [W-1:0] b);
    sub = {a[W-1], a} - {b[W-1], b};
  endfunction

  // Centre: lo plus half the span, the half truncated toward zero.
  function automatic logic signed [W:0] centre(input logic signed [W-1:0] lo,
                                               input logic signed [W-1:0] hi);
    logic signed [W:0] span;
    logic signed [W:0] span_adj;
    logic signed [W:0] half;
    span     = sub(hi, lo);
    span_adj = span + {{W{1'b0}}, span[W]};
    half     = span_adj >>> 1;
    centre   = {lo[W-1], lo} + half;
  endfunction

  logic              horiz;
  feat_flags_t       flags_d, flags1_q, flags2_q;
  logic signed [W:0] raw_near, raw_far;
  logic signed [W:0] c_src, c_box, c_diff;
  logic        [W:0] c_neg;
  logic [W-1:0]      near_d, far_d, minor;
  logic [W-1:0]      near1_q, far1_q, near2_q, far2_q;
  logic [SQ_W-1:0]   sq_maj_d, sq_min_d, sq_maj_q, sq_min_q;
  logic [WT_W-1:0]   wt_d, wt_q;

  assign horiz = (dir_i == DIR_LEFT) || (dir_i == DIR_RIGHT);

  // Direction test and major-axis distances per direction.
  always_comb begin
    flags_d = '0;
    case (dir_i)
      DIR_LEFT: begin
        flags_d.in_dir = (src_right_i > box_right_i || src_left_i >= box_right_i) &&
                         (src_left_i > box_left_i);
        flags_d.toward = src_left_i >= box_right_i;
        raw_near       = sub(src_left_i, box_right_i);
        raw_far        = sub(src_left_i, box_left_i);
      end
      DIR_RIGHT: begin
        flags_d.in_dir = (src_left_i < box_left_i || src_right_i <= box_left_i) &&
                         (src_right_i < box_right_i);
        flags_d.toward = src_right_i <= box_left_i;
        raw_near       = sub(box_left_i, src_right_i);
        raw_far        = sub(box_right_i, src_right_i);
      end
      DIR_UP: begin
        flags_d.in_dir = (src_bottom_i > box_bottom_i || src_top_i >= box_bottom_i) &&
                         (src_top_i > box_top_i);
        flags_d.toward = src_top_i >= box_bottom_i;
        raw_near       = sub(src_top_i, box_bottom_i);
        raw_far        = sub(src_top_i, box_top_i);
      end
      default: begin
        flags_d.in_dir = (src_top_i < box_top_i || src_bottom_i <= box_top_i) &&
                         (src_bottom_i < box_bottom_i);
        flags_d.toward = src_bottom_i <= box_top_i;
        raw_near       = sub(box_top_i, src_bottom_i);
        raw_far        = sub(box_bottom_i, src_bottom_i);
      end
    endcase
    flags_d.beam = horiz ? (box_bottom_i >= src_top_i && box_top_i <= src_bottom_i)
                         : (box_right_i >= src_left_i && box_left_i <= src_right_i);
  end

  // Near distance clamps at zero, far distance at one.
  assign near_d = raw_near[W] ? '0 : raw_near[W-1:0];
  assign far_d  = (raw_near[W] && 1'b0) || raw_far[W] || (raw_far == '0)
                ? {{(W-1){1'b0}}, 1'b1} : raw_far[W-1:0];

  // Minor-axis distance between the centres.
  always_comb begin
    if (horiz) begin
      c_src = centre(src_top_i, src_bottom_i);
      c_box = centre(box_top_i, box_bottom_i);
    end else begin
      c_src = centre(src_left_i, src_right_i);
      c_box = centre(box_left_i, box_right_i);
    end
  end

  assign c_diff = c_src - c_box;
  assign c_neg  = -c_diff;
  assign minor  = c_diff[W] ? c_neg[W-1:0] : c_diff[W-1:0];

  assign sq_maj_d = SQ_W'(near_d) * SQ_W'(near_d);
  assign sq_min_d = SQ_W'(minor) * SQ_W'(minor);

  // First stage: flags, distances and squares.
  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      flags1_q <= flags_d;
      near1_q  <= near_d;
      far1_q   <= far_d;
      sq_maj_q <= sq_maj_d;
      sq_min_q <= sq_min_d;
    end
  end

  // Weighted distance: 13 times the major square plus the minor square.
  assign wt_d = (WT_W'(sq_maj_q) << 3) + (WT_W'(sq_maj_q) << 2) +
                WT_W'(sq_maj_q) + WT_W'(sq_min_q);

  // Second stage: weight and the terms carried alongside it.
  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      flags2_q <= flags1_q;
      near2_q  <= near1_q;
      far2_q   <= far1_q;
      wt_q     <= wt_d;
    end
  end

  assign flags_o = flags2_q;
  assign near_o  = near2_q;
  assign far_o   = far2_q;
  assign wt_o    = wt_q;

endmodule

// ===== sv/dfs_sel.sv =====
// Best-candidate selection, running best state and the result register.
// Depends on dfs_pkg for the flag struct.
module dfs_sel #(
  parameter int unsigned W     = 18,
  parameter int unsigned ID_W  = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  horiz_i,
  input  logic                  item_valid_i,
  input  logic                  item_skip_i,
  input  logic                  item_last_i,
  input  logic [ID_W-1:0]       item_id_i,
  input  dfs_pkg::feat_flags_t  cand_flags_i,
  input  logic [W-1:0]          cand_near_i,
  input  logic [W-1:0]          cand_far_i,
  input  logic [2*W+3:0]        cand_wt_i,
  input  dfs_pkg::feat_flags_t  start_flags_i,
  input  logic [W-1:0]          start_near_i,
  input  logic [W-1:0]          start_far_i,
  input  logic [2*W+3:0]        start_wt_i,
  input  logic                  reload_i,
  input  dfs_pkg::feat_flags_t  load_flags_i,
  input  logic [W-1:0]          load_near_i,
  input  logic [W-1:0]          load_far_i,
  input  logic [2*W+3:0]        load_wt_i,
  output logic                  take_o,
  output logic                  consume_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ID_W-1:0]       best_id_o,
  output logic                  found_o
);
  import dfs_pkg::*;

  localparam int unsigned WT_W = 2 * W + 4;

  feat_flags_t     best_flags_q, b_flags;
  logic [W-1:0]    best_near_q, best_far_q, b_near, b_far;
  logic [WT_W-1:0] best_wt_q, b_wt;
  logic [ID_W-1:0] best_id_q, res_id_q;
  logic            have_best_q, res_valid_q, res_found_q;
  logic            beam_cb, beam_bc, better, take, fire;

  // The running best falls back to the shifted source while empty.
  assign b_flags = have_best_q ? best_flags_q : start_flags_i;
  assign b_near  = have_best_q ? best_near_q  : start_near_i;
  assign b_far   = have_best_q ? best_far_q   : start_far_i;
  assign b_wt    = have_best_q ? best_wt_q    : start_wt_i;

  // Exclusive beam wins in both orders, then the weighted distance.
  assign beam_cb = !b_flags.beam && cand_flags_i.beam &&
                   (!b_flags.toward || horiz_i || (cand_near_i < b_far));
  assign beam_bc = !cand_flags_i.beam && b_flags.beam &&
                   (!cand_flags_i.toward || horiz_i || (b_near < cand_far_i));
  assign better  = cand_flags_i.in_dir &&
                   (!b_flags.in_dir || beam_cb || (!beam_bc && (cand_wt_i < b_wt)));

  // A last beat waits only while an untaken result holds the register.
  assign consume_o = !(item_last_i && res_valid_q && out_stall_i);
  assign fire      = item_valid_i && consume_o;
  assign take      = fire && !item_skip_i && better;
  assign take_o    = take;

  // Control state: best presence and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (fire && item_last_i) begin
        have_best_q <= 1'b0;
        res_valid_q <= 1'b1;
      end else begin
        if (take) begin
          have_best_q <= 1'b1;
        end
        if (res_valid_q && !out_stall_i) begin
          res_valid_q <= 1'b0;
        end
      end
    end
  end

  // Payload: best terms and the result beat. After a register write the
  // stored terms are replaced by those of the best rectangle re-rated
  // against the new source.
  always_ff @(posedge clk_i) begin
    if (take) begin
      best_flags_q <= cand_flags_i;
      best_near_q  <= cand_near_i;
      best_far_q   <= cand_far_i;
      best_wt_q    <= cand_wt_i;
      best_id_q    <= item_id_i;
    end else if (reload_i) begin
      best_flags_q <= load_flags_i;
      best_near_q  <= load_near_i;
      best_far_q   <= load_far_i;
      best_wt_q    <= load_wt_i;
    end
    if (fire && item_last_i) begin
      res_found_q <= take || have_best_q;
      if (take) begin
        res_id_q <= item_id_i;
      end else if (have_best_q) begin
        res_id_q <= best_id_q;
      end else begin
        res_id_q <= '0;
      end
    end
  end

  assign out_valid_o = res_valid_q;
  assign best_id_o   = res_id_q;
  assign found_o     = res_found_q;

endmodule

// ===== sv/directional_focus_search.sv =====
// Top level of the directional focus search: config registers and pipeline.
// Depends on dfs_pkg, dfs_feat and dfs_sel.
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+-------------------------------------
//   input    | in_valid_i   | in_stall_o   | cand_left/top/right/bottom_i, cand_id_i,
//            |              |              | last_cand_i
//   output   | out_valid_o  | out_stall_i  | best_id_o, found_o
//   config   | cfg_we_i     | (none)       | cfg_idx_i, cfg_data_i
//
// One candidate beat is taken every cycle unless in_stall_o is high. The result of
// a last beat passes the input register, square stage and weight stage, then
// the compare against the stored best loads the result register.
// Reset clears the configuration registers, the pipeline valids and the best.
// After a register write the stored best is re-rated against the new source,
// before any beat taken after the write reaches the compare.
// Input stalls only when a last beat at the compare meets an untaken result and
// every stage before it is full.
module directional_focus_search #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned ID_BITS    = 10
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [dfs_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [((COORD_BITS > ID_BITS) ? COORD_BITS : ID_BITS)-1:0] cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [COORD_BITS-1:0]           cand_left_i,
  input  logic signed [COORD_BITS-1:0]           cand_top_i,
  input  logic signed [COORD_BITS-1:0]           cand_right_i,
  input  logic signed [COORD_BITS-1:0]           cand_bottom_i,
  input  logic        [ID_BITS-1:0]              cand_id_i,
  input  logic                                   last_cand_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic        [ID_BITS-1:0]              best_id_o,
  output logic                                   found_o
);
  import dfs_pkg::*;

  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned W    = COORD_BITS + 2;
  localparam int unsigned WT_W = 2 * W + 4;
  localparam logic signed [W-1:0] ONE_W = W'(1);

  // Configuration registers.
  dir_e                dir_q;
  logic [CW-1:0]       src_left_q, src_top_q, src_right_q, src_bottom_q;
  logic [ID_BITS-1:0]  skip_id_q, root_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q        <= DIR_LEFT;
      src_left_q   <= '0;
      src_top_q    <= '0;
      src_right_q  <= '0;
      src_bottom_q <= '0;
      skip_id_q    <= '0;
      root_id_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DIR:        dir_q        <= dir_e'(cfg_data_i[DIR_W-1:0]);
        CFG_SRC_LEFT:   src_left_q   <= cfg_data_i[CW-1:0];
        CFG_SRC_TOP:    src_top_q    <= cfg_data_i[CW-1:0];
        CFG_SRC_RIGHT:  src_right_q  <= cfg_data_i[CW-1:0];
        CFG_SRC_BOTTOM: src_bottom_q <= cfg_data_i[CW-1:0];
        CFG_SKIP_ID:    skip_id_q    <= cfg_data_i[ID_BITS-1:0];
        CFG_ROOT_ID:    root_id_q    <= cfg_data_i[ID_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Delay line that marks when the best's terms have caught up with a write.
  logic [2:0] cfg_dly_q;
  logic       reload;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_dly_q <= '0;
    end else begin
      cfg_dly_q <= {cfg_dly_q[1:0], cfg_we_i};
    end
  end

  assign reload = cfg_dly_q[2];

  // Source and shifted start rectangle, widened so that the shift is exact.
  logic signed [W-1:0] s_l, s_t, s_r, s_b, s_w, s_h;
  logic signed [W-1:0] st_l, st_t, st_r, st_b;
  logic                horiz;

  assign s_l = {{2{src_left_q[CW-1]}}, src_left_q};
  assign s_t = {{2{src_top_q[CW-1]}}, src_top_q};
  assign s_r = {{2{src_right_q[CW-1]}}, src_right_q};
  assign s_b = {{2{src_bottom_q[CW-1]}}, src_bottom_q};
  assign s_w = s_r - s_l + ONE_W;
  assign s_h = s_b - s_t + ONE_W;
  assign horiz = (dir_q == DIR_LEFT) || (dir_q == DIR_RIGHT);

  always_comb begin
    st_l = s_l;
    st_t = s_t;
    st_r = s_r;
    st_b = s_b;
    case (dir_q)
      DIR_LEFT: begin
        st_l = s_l + s_w;
        st_r = s_r + s_w;
      end
      DIR_RIGHT: begin
        st_l = s_l - s_w;
        st_r = s_r - s_w;
      end
      DIR_UP: begin
        st_t = s_t + s_h;
        st_b = s_b + s_h;
      end
      default: begin
        st_t = s_t - s_h;
        st_b = s_b - s_h;
      end
    endcase
  end

  // Pipeline handshake: each stage loads when it is empty or moves on.
  logic v0_q, v1_q, v2_q;
  logic rdy0, rdy1, rdy2, consume;

  assign rdy2       = !v2_q || consume;
  assign rdy1       = !v1_q || rdy2;
  assign rdy0       = !v0_q || rdy1;
  assign in_stall_o = !rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_q <= in_valid_i;
      end
      if (rdy1) begin
        v1_q <= v0_q;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  // Input register for the candidate beat.
  logic [CW-1:0]      c_l_q, c_t_q, c_r_q, c_b_q;
  logic [ID_BITS-1:0] id0_q, id1_q, id2_q;
  logic               last0_q, last1_q, last2_q;
  logic               skip_d, skip1_q, skip2_q;

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      c_l_q   <= cand_left_i;
      c_t_q   <= cand_top_i;
      c_r_q   <= cand_right_i;
      c_b_q   <= cand_bottom_i;
      id0_q   <= cand_id_i;
      last0_q <= last_cand_i;
    end
  end

  // Skip test on the focused item and the container.
  assign skip_d = ((skip_id_q != '0) && (id0_q == skip_id_q)) ||
                  ((root_id_q != '0) && (id0_q == root_id_q));

  // Side band that travels with the feature stages.
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      id1_q   <= id0_q;
      last1_q <= last0_q;
      skip1_q <= skip_d;
    end
    if (rdy2) begin
      id2_q   <= id1_q;
      last2_q <= last1_q;
      skip2_q <= skip1_q;
    end
  end

  // Candidate rectangle carried to the compare, and the rectangle of the best.
  logic [CW-1:0] c_l1_q, c_t1_q, c_r1_q, c_b1_q;
  logic [CW-1:0] c_l2_q, c_t2_q, c_r2_q, c_b2_q;
  logic [CW-1:0] b_l_q, b_t_q, b_r_q, b_b_q;
  logic          take;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      c_l1_q <= c_l_q;
      c_t1_q <= c_t_q;
      c_r1_q <= c_r_q;
      c_b1_q <= c_b_q;
    end
    if (rdy2) begin
      c_l2_q <= c_l1_q;
      c_t2_q <= c_t1_q;
      c_r2_q <= c_r1_q;
      c_b2_q <= c_b1_q;
    end
    if (take) begin
      b_l_q <= c_l2_q;
      b_t_q <= c_t2_q;
      b_r_q <= c_r2_q;
      b_b_q <= c_b2_q;
    end
  end

  // Candidate features.
  feat_flags_t     c_flags, st_flags, b_flags;
  logic [W-1:0]    c_near, c_far, st_near, st_far, b_near, b_far;
  logic [WT_W-1:0] c_wt, st_wt, b_wt;

  dfs_feat #(.W(W)) u_cand_feat (
    .clk_i        (clk_i),
    .en1_i        (rdy1),
    .en2_i        (rdy2),
    .dir_i        (dir_q),
    .src_left_i   (s_l),
    .src_top_i    (s_t),
    .src_right_i  (s_r),
    .src_bottom_i (s_b),
    .box_left_i   ({{2{c_l_q[CW-1]}}, c_l_q}),
    .box_top_i    ({{2{c_t_q[CW-1]}}, c_t_q}),
    .box_right_i  ({{2{c_r_q[CW-1]}}, c_r_q}),
    .box_bottom_i ({{2{c_b_q[CW-1]}}, c_b_q}),
    .flags_o      (c_flags),
    .near_o       (c_near),
    .far_o        (c_far),
    .wt_o         (c_wt)
  );

  // Start rectangle features, tracking the configuration every cycle.
  dfs_feat #(.W(W)) u_start_feat (
    .clk_i        (clk_i),
    .en1_i        (1'b1),
    .en2_i        (1'b1),
    .dir_i        (dir_q),
    .src_left_i   (s_l),
    .src_top_i    (s_t),
    .src_right_i  (s_r),
    .src_bottom_i (s_b),
    .box_left_i   (st_l),
    .box_top_i    (st_t),
    .box_right_i  (st_r),
    .box_bottom_i (st_b),
    .flags_o      (st_flags),
    .near_o       (st_near),
    .far_o        (st_far),
    .wt_o         (st_wt)
  );

  // Best rectangle features against the current configuration.
  dfs_feat #(.W(W)) u_best_feat (
    .clk_i        (clk_i),
    .en1_i        (1'b1),
    .en2_i        (1'b1),
    .dir_i        (dir_q),
    .src_left_i   (s_l),
    .src_top_i    (s_t),
    .src_right_i  (s_r),
    .src_bottom_i (s_b),
    .box_left_i   ({{2{b_l_q[CW-1]}}, b_l_q}),
    .box_top_i    ({{2{b_t_q[CW-1]}}, b_t_q}),
    .box_right_i  ({{2{b_r_q[CW-1]}}, b_r_q}),
    .box_bottom_i ({{2{b_b_q[CW-1]}}, b_b_q}),
    .flags_o      (b_flags),
    .near_o       (b_near),
    .far_o        (b_far),
    .wt_o         (b_wt)
  );

  // Compare against the running best and emit the result beat.
  dfs_sel #(.W(W), .ID_W(ID_BITS)) u_sel (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .horiz_i       (horiz),
    .item_valid_i  (v2_q),
    .item_skip_i   (skip2_q),
    .item_last_i   (last2_q),
    .item_id_i     (id2_q),
    .cand_flags_i  (c_flags),
    .cand_near_i   (c_near),
    .cand_far_i    (c_far),
    .cand_wt_i     (c_wt),
    .start_flags_i (st_flags),
    .start_near_i  (st_near),
    .start_far_i   (st_far),
    .start_wt_i    (st_wt),
    .reload_i      (reload),
    .load_flags_i  (b_flags),
    .load_near_i   (b_near),
    .load_far_i    (b_far),
    .load_wt_i     (b_wt),
    .take_o        (take),
    .consume_o     (consume),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .best_id_o     (best_id_o),
    .found_o       (found_o)
  );

endmodule
